>>> design/bcr_pkg.sv
// Package with shared types and constants for the Bresenham circle rasterizer.
package bcr_pkg;

  localparam int unsigned COORD_BITS_DEF  = 16;
  localparam int unsigned RADIUS_BITS_DEF = 14;

  typedef struct packed {
    logic load;
    logic done;
  } bcr_grp_ctl_t;

  typedef enum logic [2:0] {
    PIX_MX_MY = 3'd0,
    PIX_MY_MX = 3'd1,
    PIX_MX_PY = 3'd2,
    PIX_PY_MX = 3'd3,
    PIX_PX_MY = 3'd4,
    PIX_MY_PX = 3'd5,
    PIX_PX_PY = 3'd6,
    PIX_PY_PX = 3'd7
  } bcr_slot_t;

endpackage

>>> design/bcr_step.sv
// Octant walker: holds center, offsets and error term, and takes one Bresenham step per item.
module bcr_step
  import bcr_pkg::*;
#(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic                          op,
  input  logic signed [COORD_BITS-1:0]  center_x,
  input  logic signed [COORD_BITS-1:0]  center_y,
  input  logic        [RADIUS_BITS-1:0] radius,
  output bcr_grp_ctl_t                  ctl,
  output logic signed [COORD_BITS-1:0]  g_cx,
  output logic signed [COORD_BITS-1:0]  g_cy,
  output logic signed [RADIUS_BITS:0]   g_dx,
  output logic signed [RADIUS_BITS:0]   g_dy
);

  localparam int unsigned DW = RADIUS_BITS + 1;
  localparam int unsigned EW = RADIUS_BITS + 6;
  localparam int unsigned AW = EW + 2;

  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic signed [DW-1:0]         dx_r, dy_r;
  logic signed [EW-1:0]         e_r;
  logic                         active_r;

  logic                         start;
  logic                         cur_act;
  logic signed [COORD_BITS-1:0] cur_cx, cur_cy;
  logic signed [DW-1:0]         cur_dx, cur_dy;
  logic signed [EW-1:0]         cur_e, init_e;

  logic signed [AW-1:0] ea, xa, ya, xa1, ya1, diag, nx, ny, ne, gap;
  logic                 done;

  assign start  = !op;
  assign init_e = EW'(2) - (EW'(radius) <<< 1);

  always_comb begin
    if (start) begin
      cur_cx = center_x;
      cur_cy = center_y;
      cur_dx = '0;
      cur_dy = DW'(radius);
      cur_e  = init_e;
    end else begin
      cur_cx = cx_r;
      cur_cy = cy_r;
      cur_dx = dx_r;
      cur_dy = dy_r;
      cur_e  = e_r;
    end
  end

  assign cur_act = start || active_r;

  always_comb begin
    ea   = AW'(cur_e);
    xa   = AW'(cur_dx);
    ya   = AW'(cur_dy);
    xa1  = xa + AW'(1);
    ya1  = ya - AW'(1);
    diag = (xa1 - ya1 + AW'(1)) <<< 1;
    nx   = xa1;
    ny   = ya1;
    ne   = ea + diag;
    priority if (ea[AW-1]) begin
      if ((ea + ya) > AW'(0)) begin
        ne = ea + diag;
      end else begin
        ny = ya;
        ne = ea + (xa1 <<< 1) + AW'(1);
      end
    end else if (ea != AW'(0)) begin
      if ((ea - xa) <= AW'(0)) begin
        ne = ea + diag;
      end else begin
        nx = xa;
        ne = ea - (ya1 <<< 1) + AW'(1);
      end
    end else begin
      ne = ea + diag;
    end
    gap  = ny - nx;
    done = gap[AW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (acc && cur_act) begin
      active_r <= !done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      dx_r <= '0;
      dy_r <= '0;
      e_r  <= '0;
    end else if (acc && cur_act) begin
      cx_r <= cur_cx;
      cy_r <= cur_cy;
      dx_r <= nx[DW-1:0];
      dy_r <= ny[DW-1:0];
      e_r  <= ne[EW-1:0];
    end
  end

  assign ctl.load = acc && cur_act;
  assign ctl.done = done;
  assign g_cx     = cur_cx;
  assign g_cy     = cur_cy;
  assign g_dx     = cur_dx;
  assign g_dy     = cur_dy;

endmodule

>>> design/bcr_emit.sv
// Group register and pixel emitter: sends one step's eight mirrored pixels, one per cycle unless stalled.
module bcr_emit
  import bcr_pkg::*;
#(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bcr_grp_ctl_t                 ctl,
  input  logic signed [COORD_BITS-1:0] g_cx,
  input  logic signed [COORD_BITS-1:0] g_cy,
  input  logic signed [RADIUS_BITS:0]  g_dx,
  input  logic signed [RADIUS_BITS:0]  g_dy,
  output logic                         free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS:0]   out_pixel_x,
  output logic signed [COORD_BITS:0]   out_pixel_y,
  output logic                         out_last_of_group,
  output logic                         out_circle_done
);

  localparam int unsigned DW = RADIUS_BITS + 1;
  localparam int unsigned OW = COORD_BITS + 1;
  localparam int unsigned SW = ((COORD_BITS > DW) ? COORD_BITS : DW) + 1;

  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic signed [DW-1:0]         dx_r, dy_r;
  logic                         done_r;
  logic                         grp_valid_r;
  bcr_slot_t                    slot_r;

  logic                         out_valid_r;
  logic signed [OW-1:0]         px_r, py_r;
  logic                         last_r, cdone_r;

  logic                         emit_go;
  logic                         is_last;
  logic signed [SW-1:0]         sx, sy, sdx, sdy;
  logic signed [SW-1:0]         x_sel, y_sel;

  assign emit_go = grp_valid_r && (!out_valid_r || out_ready);
  assign is_last = (slot_r == PIX_PY_PX);
  assign free    = !grp_valid_r || (emit_go && is_last);

  assign sx  = SW'(cx_r);
  assign sy  = SW'(cy_r);
  assign sdx = SW'(dx_r);
  assign sdy = SW'(dy_r);

  always_comb begin
    unique case (slot_r)
      PIX_MX_MY: begin x_sel = sx - sdx; y_sel = sy - sdy; end
      PIX_MY_MX: begin x_sel = sx - sdy; y_sel = sy - sdx; end
      PIX_MX_PY: begin x_sel = sx - sdx; y_sel = sy + sdy; end
      PIX_PY_MX: begin x_sel = sx + sdy; y_sel = sy - sdx; end
      PIX_PX_MY: begin x_sel = sx + sdx; y_sel = sy - sdy; end
      PIX_MY_PX: begin x_sel = sx - sdy; y_sel = sy + sdx; end
      PIX_PX_PY: begin x_sel = sx + sdx; y_sel = sy + sdy; end
      PIX_PY_PX: begin x_sel = sx + sdy; y_sel = sy + sdx; end
      default:   begin x_sel = sx;       y_sel = sy;       end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      slot_r      <= PIX_MX_MY;
    end else if (ctl.load) begin
      grp_valid_r <= 1'b1;
      slot_r      <= PIX_MX_MY;
    end else if (emit_go) begin
      grp_valid_r <= !is_last;
      slot_r      <= bcr_slot_t'(3'(slot_r + 3'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cx_r   <= g_cx;
      cy_r   <= g_cy;
      dx_r   <= g_dx;
      dy_r   <= g_dy;
      done_r <= ctl.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      px_r    <= x_sel[OW-1:0];
      py_r    <= y_sel[OW-1:0];
      last_r  <= is_last;
      cdone_r <= is_last && done_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_x       = px_r;
  assign out_pixel_y       = py_r;
  assign out_last_of_group = last_r;
  assign out_circle_done   = cdone_r;

endmodule

>>> design/bresenham_circle_raster.sv
// Top level of the Bresenham circle rasterizer with eight-way symmetry.
//
// Channel  Direction  Ports
// in       input      in_valid, in_ready, in_op, in_center_x, in_center_y, in_radius
// out      output     out_valid, out_ready, out_pixel_x, out_pixel_y,
//                     out_last_of_group, out_circle_done
//
// An active item yields eight pixels, one per cycle from the output register
// while the output is not stalled, and no new item is taken while the group is still being emitted.
// The next item is accepted in the cycle the eighth pixel enters the output register.
// A continue item with no circle in progress is accepted once the emitter is free and yields nothing.
// Reset is synchronous and clears the walk state and all valid flags.
// A stalled output holds its pixel and pauses the group in progress.
module bresenham_circle_raster
  import bcr_pkg::*;
#(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic signed [COORD_BITS-1:0]  in_center_x,
  input  logic signed [COORD_BITS-1:0]  in_center_y,
  input  logic        [RADIUS_BITS-1:0] in_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS:0]    out_pixel_x,
  output logic signed [COORD_BITS:0]    out_pixel_y,
  output logic                          out_last_of_group,
  output logic                          out_circle_done
);

  bcr_grp_ctl_t                 ctl;
  logic signed [COORD_BITS-1:0] g_cx, g_cy;
  logic signed [RADIUS_BITS:0]  g_dx, g_dy;
  logic                         free;
  logic                         in_acc;

  assign in_ready = free;
  assign in_acc   = in_valid && free;

  bcr_step #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .op       (in_op),
    .center_x (in_center_x),
    .center_y (in_center_y),
    .radius   (in_radius),
    .ctl      (ctl),
    .g_cx     (g_cx),
    .g_cy     (g_cy),
    .g_dx     (g_dx),
    .g_dy     (g_dy)
  );

  bcr_emit #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .g_cx              (g_cx),
    .g_cy              (g_cy),
    .g_dx              (g_dx),
    .g_dy              (g_dy),
    .free              (free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_last_of_group (out_last_of_group),
    .out_circle_done   (out_circle_done)
  );

`ifndef ASSERT_OFF
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_circle_done || out_last_of_group))
    else $error("circle_done raised on a pixel that does not close its group");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_op) |=> !in_ready)
    else $error("a start item did not occupy the emitter");

  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_group) |=> out_valid)
    else $error("a group stopped before its last pixel");
`endif

endmodule

>>> tb/sv/testbench.sv
// Testbench for the Bresenham circle rasterizer: directed and random items checked per pixel.
module testbench;
  import bcr_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int RW = RADIUS_BITS_DEF;
  localparam logic OP_START = 1'b0;
  localparam logic OP_CONTINUE = 1'b1;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic signed [CW:0] x;
    logic signed [CW:0] y;
    logic last;
    logic done;
  } pixel_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = OP_CONTINUE;
  logic signed [CW-1:0] in_center_x = '0;
  logic signed [CW-1:0] in_center_y = '0;
  logic [RW-1:0] in_radius = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW:0] out_pixel_x;
  logic signed [CW:0] out_pixel_y;
  logic out_last_of_group;
  logic out_circle_done;

  pixel_t expected_pixels[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int send_idle_pct = 32;
  int recv_stall_pct = 54;

  logic signed [CW-1:0] circ_cx = '0;
  logic signed [CW-1:0] circ_cy = '0;
  int walk_dx = 0;
  int walk_dy = 0;
  int walk_err = 0;
  bit walk_active = 1'b0;

  bresenham_circle_raster DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_center_x(in_center_x),
    .in_center_y(in_center_y),
    .in_radius(in_radius),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pixel_x(out_pixel_x),
    .out_pixel_y(out_pixel_y),
    .out_last_of_group(out_last_of_group),
    .out_circle_done(out_circle_done)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[bresenham_circle_raster] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel (%0d,%0d)", out_pixel_x, out_pixel_y));
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_pixel_x !== exp_px.x || out_pixel_y !== exp_px.y ||
            out_last_of_group !== exp_px.last || out_circle_done !== exp_px.done) begin
          report_mismatch($sformatf("got (%0d,%0d) last %b done %b, want (%0d,%0d) last %b done %b",
                                    out_pixel_x, out_pixel_y, out_last_of_group,
                                    out_circle_done, exp_px.x, exp_px.y, exp_px.last,
                                    exp_px.done));
        end
      end
    end
  end

  // Mirrors the walk for one accepted item and, if a circle is active, queues the eight pixels it produces.
  task automatic predict_raster(input logic op, input logic signed [CW-1:0] cx,
                                input logic signed [CW-1:0] cy, input logic [RW-1:0] r);
    int dx;
    int dy;
    int t;
    int xi;
    int yi;
    bit fin;
    pixel_t px;
    if (op == OP_START) begin
      circ_cx = cx;
      circ_cy = cy;
      walk_dx = 0;
      walk_dy = int'(r);
      walk_err = 2 * (1 - int'(r));
      walk_active = 1'b1;
    end
    if (!walk_active) return;
    dx = walk_dx;
    dy = walk_dy;
    if (walk_err < 0) begin
      t = 2 * (walk_err + walk_dy) - 1;
      walk_dx++;
      if (t > 0) begin
        walk_dy--;
        walk_err += 2 * (walk_dx - walk_dy + 1);
      end else begin
        walk_err += 2 * walk_dx + 1;
      end
    end else if (walk_err > 0) begin
      t = 2 * (walk_err - walk_dx) - 1;
      walk_dy--;
      if (t <= 0) begin
        walk_dx++;
        walk_err += 2 * (walk_dx - walk_dy + 1);
      end else begin
        walk_err += -2 * walk_dy + 1;
      end
    end else begin
      walk_dx++;
      walk_dy--;
      walk_err += 2 * (walk_dx - walk_dy + 1);
    end
    fin = (walk_dy - walk_dx < 0);
    if (fin) walk_active = 1'b0;
    for (int k = 0; k < 8; k++) begin
      case (bcr_slot_t'(3'(k)))
        PIX_MX_MY: begin xi = int'(circ_cx) - dx; yi = int'(circ_cy) - dy; end
        PIX_MY_MX: begin xi = int'(circ_cx) - dy; yi = int'(circ_cy) - dx; end
        PIX_MX_PY: begin xi = int'(circ_cx) - dx; yi = int'(circ_cy) + dy; end
        PIX_PY_MX: begin xi = int'(circ_cx) + dy; yi = int'(circ_cy) - dx; end
        PIX_PX_MY: begin xi = int'(circ_cx) + dx; yi = int'(circ_cy) - dy; end
        PIX_MY_PX: begin xi = int'(circ_cx) - dy; yi = int'(circ_cy) + dx; end
        PIX_PX_PY: begin xi = int'(circ_cx) + dx; yi = int'(circ_cy) + dy; end
        default:   begin xi = int'(circ_cx) + dy; yi = int'(circ_cy) + dx; end
      endcase
      px.x = (CW+1)'(xi);
      px.y = (CW+1)'(yi);
      px.last = (k == 7);
      px.done = (k == 7) && fin;
      expected_pixels.push_back(px);
    end
  endtask

  task automatic send_item(input logic op, input logic signed [CW-1:0] cx,
                           input logic signed [CW-1:0] cy, input logic [RW-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius <= r;
    do @(posedge clk); while (!in_ready);
    predict_raster(op, cx, cy, r);
    items_sent++;
  endtask

  task automatic send_continue();
    send_item(OP_CONTINUE, CW'($urandom), CW'($urandom), RW'($urandom));
  endtask

  task automatic finish_circle();
    while (walk_active) send_continue();
  endtask

  task automatic wait_for_pixels();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic test_idle_continue();
    send_continue();
    send_item(OP_CONTINUE, 16'sh7fff, -16'sh8000, '1);
  endtask

  task automatic test_zero_radius();
    send_item(OP_START, -16'sh8000, 16'sh7fff, '0);
    send_continue();
    send_item(OP_START, 16'sh7fff, -16'sh8000, '0);
  endtask

  task automatic test_small_circles();
    send_item(OP_START, 16'sh0010, -16'sh0020, 14'd1);
    finish_circle();
    send_item(OP_START, -16'sh0005, 16'sh0003, 14'd2);
    finish_circle();
    send_item(OP_START, 16'sh1234, -16'sh1234, 14'd3);
    finish_circle();
    send_continue();
  endtask

  task automatic test_start_while_busy();
    send_item(OP_START, 16'sh7fff, -16'sh8000, 14'h3fff);
    repeat (3) send_continue();
    send_item(OP_START, -16'sh8000, -16'sh8000, 14'h3fff);
    send_continue();
    send_item(OP_START, 16'sh0000, 16'sh0000, 14'd5);
    finish_circle();
  endtask

  // Mostly whole circles with random centers, plus abandoned walks and stray continues.
  task automatic test_random_traffic(input int count);
    int stop_at;
    int pick;
    int steps;
    logic [RW-1:0] r;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        if ($urandom_range(99) < 5) r = RW'($urandom);
        else if ($urandom_range(99) < 20) r = RW'($urandom_range(31, 60));
        else r = RW'($urandom_range(0, 30));
        send_item(OP_START, CW'($urandom), CW'($urandom), r);
        steps = 0;
        while (walk_active && items_sent < stop_at) begin
          if (r > 60 && steps >= 6) break;
          if ($urandom_range(99) < 3) break;
          send_continue();
          steps++;
        end
      end else begin
        send_continue();
      end
      if (pick == 99) wait_for_pixels();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_continue();
    test_zero_radius();
    test_small_circles();
    test_start_while_busy();
    wait_for_pixels();
    test_random_traffic(70);
    wait_for_pixels();
    send_idle_pct = 54;
    recv_stall_pct = 32;
    test_random_traffic(70);
    wait_for_pixels();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(70);
    wait_for_pixels();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[bresenham_circle_raster] OK");
    end else begin
      $display("[bresenham_circle_raster] ERROR");
    end
    $finish;
  end

endmodule
